FILE: rtl/pitf_pkg.sv
`default_nettype none
package pitf_pkg;

    // Pulse ID field and its wrap
    localparam logic [16:0] PID_MASK = 17'h1FFFF;
    localparam logic [17:0] PID_WRAP = 18'd131040;
    localparam logic [16:0] LOST_PID_RESET = 17'd131040;

    // Ring depth default and register reset values
    localparam int DEF_RING_DEPTH = 32;
    localparam logic [7:0]  FID_RESET = 8'd3;
    localparam logic [19:0] TOL_RESET = 20'd16666;

    // Register indexes
    localparam logic CFG_FIDUCIALS = 1'b0;
    localparam logic CFG_TOLERANCE = 1'b1;

    typedef enum logic [1:0] {
        OP_TRIGGER = 2'd0,
        OP_TAG     = 2'd1,
        OP_ACQUIRE = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EXEC,
        ST_GMOD,
        ST_GCHK,
        ST_GDIV,
        ST_GMUL,
        ST_GWRAP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] stamp_seconds;
        logic [31:0] stamp_nsec;
        logic        time_ok;
        logic [19:0] elapsed_us;
        logic        acquire;
    } item_t;

    typedef struct packed {
        logic        status;
        logic [31:0] tag_seconds;
        logic [31:0] tag_nsec;
        logic        trigger_enable;
        logic [31:0] lost_image_total;
        logic [31:0] resync_total;
        logic [31:0] invalid_pulse_total;
        logic [16:0] last_lost_pulse_id;
        logic [5:0]  fifo_count;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/pulse_id_tag_fifo_unit.sv
`default_nettype none
// Pulse ID timestamp ring for camera image tagging.
// Command channel: an item (item) is taken when start is high and busy low.
// Op trigger pushes the event stamp, op tag pops the oldest stamp as the
// image tag, op acquire restarts the ring, op restart re-enables the trigger.
// Each item yields one result on result, shown for one cycle with done high;
// the receiver cannot stall and must take it in that cycle.
// Configuration: cfg_we with cfg_index and cfg_data writes a register at
// once; write only while busy is low.
// Sequence: trigger, acquire and restart items, and tags on an empty ring or
// with a repeated ID, pass from acceptance through load, execute and finish
// to done. Other tags run the gap check: wrap reduction of the gap and a
// compare. When images are lost, a bit-serial restoring divide by the
// fiducial step follows, then a multiply and a wrap reduction of the
// product.
// One item is in flight at a time; the next may start in the cycle its
// result is shown.
// Reset clears the ring pointers, counters, flags and per-entry valid bits;
// a never written entry reads as zero. No clearing pass is needed.
module pulse_id_tag_fifo_unit
    import pitf_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    output logic             done,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

    // Ring storage and per-entry valid bits
    logic [63:0]           ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] vld_reg;
    logic [63:0]           rd_tail_reg, rd_new_reg;
    logic                  vld_tail_reg, vld_new_reg;

    // Control and datapath registers
    state_t         state_reg, state_next;
    item_t          item_reg, item_next;
    logic [7:0]     fid_reg;
    logic [19:0]    tol_reg;
    logic [PTR_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic           acq_reg, acq_next, trig_reg, trig_next, pend_reg, pend_next;
    logic [16:0]    last_id_reg, last_id_next;
    logic           last_vld_reg, last_vld_next;
    logic [31:0]    lost_reg, lost_next, resync_reg, resync_next, inval_reg, inval_next;
    logic [16:0]    lost_pid_reg, lost_pid_next;
    logic           status_reg, status_next;
    logic [31:0]    tsec_reg, tsec_next, tnsec_reg, tnsec_next;
    logic [16:0]    image_reg, image_next;
    logic [17:0]    diff_reg, diff_next, prod_reg, prod_next;
    logic [16:0]    dvd_reg, dvd_next;
    logic [7:0]     rem_reg, rem_next;
    logic [4:0]     bit_cnt_reg, bit_cnt_next;
    logic           done_next;
    result_t        result_next;

    logic           wr_en;
    logic [PTR_W-1:0] head_m1;
    logic [7:0]     fid_eff;
    logic [31:0]    tail_sec, tail_nsec;
    logic [24:0]    mult_w;
    logic [8:0]     trial;

    assign head_m1 = (head_reg == '0) ? PTR_LAST : head_reg - PTR_W'(1);
    assign fid_eff = (fid_reg == 8'd0) ? 8'd1 : fid_reg;
    assign tail_sec  = vld_tail_reg ? rd_tail_reg[63:32] : 32'd0;
    assign tail_nsec = vld_tail_reg ? rd_tail_reg[31:0]  : 32'd0;
    assign mult_w = dvd_reg * fid_eff;
    assign trial  = {rem_reg, dvd_reg[16]};
    assign busy   = (state_reg != ST_IDLE);

    // Ring memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[head_reg] <= {item_reg.stamp_seconds, item_reg.stamp_nsec};
        end
        rd_tail_reg <= ring_mem[tail_reg];
        rd_new_reg  <= ring_mem[head_m1];
    end

    // Valid bits of the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            vld_tail_reg <= 1'b0;
            vld_new_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[head_reg] <= 1'b1;
            end
            vld_tail_reg <= vld_reg[tail_reg];
            vld_new_reg  <= vld_reg[head_m1];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (start) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (item_reg.op == OP_TAG && count_reg != '0 &&
                    !(last_vld_reg && last_id_reg == tail_nsec[16:0]))
                    state_next = ST_GMOD;
                else
                    state_next = ST_FINISH;
            end
            ST_GMOD:   if (diff_reg < PID_WRAP) state_next = ST_GCHK;
            ST_GCHK:   state_next = (diff_reg > {10'd0, fid_eff}) ? ST_GDIV : ST_FINISH;
            ST_GDIV:   if (bit_cnt_reg == 5'd16) state_next = ST_GMUL;
            ST_GMUL:   state_next = ST_GWRAP;
            ST_GWRAP:  if (prod_reg < PID_WRAP) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        logic        id_bad, full, dup;
        logic [1:0]  rs_inc;
        logic [17:0] sum;
        logic [16:0] newest;
        id_bad = 1'b0;
        full = 1'b0;
        dup = 1'b0;
        rs_inc = 2'd0;
        sum = '0;
        newest = '0;
        item_next = item_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        acq_next = acq_reg;
        trig_next = trig_reg;
        pend_next = pend_reg;
        last_id_next = last_id_reg;
        last_vld_next = last_vld_reg;
        lost_next = lost_reg;
        resync_next = resync_reg;
        inval_next = inval_reg;
        lost_pid_next = lost_pid_reg;
        status_next = status_reg;
        tsec_next = tsec_reg;
        tnsec_next = tnsec_reg;
        image_next = image_reg;
        diff_next = diff_reg;
        prod_next = prod_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        wr_en = 1'b0;
        done_next = 1'b0;
        result_next = result;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) item_next = item;
            end
            ST_EXEC:
            begin
                status_next = 1'b0;
                tsec_next = 32'd0;
                tnsec_next = 32'd0;
                case (item_reg.op)
                    OP_TRIGGER:
                    begin
                        id_bad = !item_reg.time_ok || (item_reg.stamp_nsec[16:0] == PID_MASK);
                        full = (count_reg >= CNT_FULL);
                        if (!item_reg.time_ok) rs_inc = 2'd1;
                        if (acq_reg)
                        begin
                            if (id_bad)
                            begin
                                inval_next = inval_reg + 32'd1;
                                rs_inc = rs_inc + 2'd1;
                            end
                            else if (!full)
                            begin
                                wr_en = 1'b1;
                                head_next = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                lost_next = lost_reg + 32'd1;
                                rs_inc = rs_inc + 2'd1;
                            end
                        end
                        if (rs_inc != 2'd0)
                        begin
                            status_next = 1'b1;
                            trig_next = 1'b0;
                            pend_next = 1'b1;
                            head_next = '0;
                            tail_next = '0;
                            count_next = '0;
                            resync_next = resync_reg + {30'd0, rs_inc};
                        end
                    end
                    OP_TAG:
                    begin
                        if (count_reg != '0)
                        begin
                            tsec_next = tail_sec;
                            tnsec_next = tail_nsec;
                            dup = last_vld_reg && (last_id_reg == tail_nsec[16:0]);
                            if (dup)
                            begin
                                tnsec_next[16:0] = PID_MASK;
                                status_next = 1'b1;
                                trig_next = 1'b0;
                                pend_next = 1'b1;
                                resync_next = resync_reg + 32'd1;
                                head_next = '0;
                                tail_next = '0;
                                count_next = '0;
                                last_id_next = PID_MASK;
                            end
                            else
                            begin
                                last_id_next = tail_nsec[16:0];
                                last_vld_next = 1'b1;
                                image_next = tail_nsec[16:0];
                                newest = vld_new_reg ? rd_new_reg[16:0] : 17'd0;
                                sum = {1'b0, newest} + PID_WRAP;
                                diff_next = (sum < {1'b0, image_next}) ? 18'd0
                                                                      : sum - {1'b0, image_next};
                                if (trig_reg && item_reg.elapsed_us > tol_reg)
                                begin
                                    tnsec_next[16:0] = PID_MASK;
                                    status_next = 1'b1;
                                    trig_next = 1'b0;
                                    pend_next = 1'b1;
                                    head_next = '0;
                                    tail_next = '0;
                                    count_next = '0;
                                end
                                else
                                begin
                                    tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + PTR_W'(1);
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        else
                        begin
                            tsec_next = item_reg.stamp_seconds;
                            tnsec_next = {tail_nsec[31:17], PID_MASK};
                        end
                    end
                    OP_ACQUIRE:
                    begin
                        if (!(item_reg.acquire && acq_reg))
                        begin
                            head_next = '0;
                            tail_next = '0;
                            count_next = '0;
                            acq_next = item_reg.acquire;
                            trig_next = item_reg.acquire;
                        end
                    end
                    default:
                    begin
                        if (pend_reg)
                        begin
                            trig_next = 1'b1;
                            pend_next = 1'b0;
                        end
                    end
                endcase
            end
            // Wrap reduction of the gap
            ST_GMOD:
            begin
                if (diff_reg >= PID_WRAP) diff_next = diff_reg - PID_WRAP;
            end
            ST_GCHK:
            begin
                dvd_next = diff_reg[16:0] - 17'd1;
                rem_next = 8'd0;
                bit_cnt_next = 5'd0;
            end
            // Restoring divide, one quotient bit per cycle
            ST_GDIV:
            begin
                if (trial >= {1'b0, fid_eff})
                begin
                    rem_next = 8'(trial - {1'b0, fid_eff});
                    dvd_next = {dvd_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[7:0];
                    dvd_next = {dvd_reg[15:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg + 5'd1;
            end
            ST_GMUL:
            begin
                prod_next = {1'b0, image_reg} + mult_w[17:0];
            end
            ST_GWRAP:
            begin
                if (prod_reg >= PID_WRAP)
                    prod_next = prod_reg - PID_WRAP;
                else
                begin
                    lost_next = lost_reg + {15'd0, dvd_reg};
                    lost_pid_next = prod_reg[16:0];
                end
            end
            ST_FINISH:
            begin
                done_next = 1'b1;
                result_next.status = status_reg;
                result_next.tag_seconds = tsec_reg;
                result_next.tag_nsec = tnsec_reg;
                result_next.trigger_enable = trig_reg;
                result_next.lost_image_total = lost_reg;
                result_next.resync_total = resync_reg;
                result_next.invalid_pulse_total = inval_reg;
                result_next.last_lost_pulse_id = lost_pid_reg;
                result_next.fifo_count = 6'(32'(count_reg));
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fid_reg      <= FID_RESET;
            tol_reg      <= TOL_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            acq_reg      <= 1'b0;
            trig_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            last_id_reg  <= '0;
            last_vld_reg <= 1'b0;
            lost_reg     <= '0;
            resync_reg   <= '0;
            inval_reg    <= '0;
            lost_pid_reg <= LOST_PID_RESET;
            done         <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_FIDUCIALS) fid_reg <= cfg_data[7:0];
                else tol_reg <= cfg_data;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            acq_reg      <= acq_next;
            trig_reg     <= trig_next;
            pend_reg     <= pend_next;
            last_id_reg  <= last_id_next;
            last_vld_reg <= last_vld_next;
            lost_reg     <= lost_next;
            resync_reg   <= resync_next;
            inval_reg    <= inval_next;
            lost_pid_reg <= lost_pid_next;
            done         <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        status_reg  <= status_next;
        tsec_reg    <= tsec_next;
        tnsec_reg   <= tnsec_next;
        image_reg   <= image_next;
        diff_reg    <= diff_next;
        prod_reg    <= prod_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        result      <= result_next;
    end

endmodule
`default_nettype wire
